@@ src/wts_pkg.sv @@
package wts_pkg;

    // Field types
    typedef logic signed [31:0] position_t;
    typedef logic [23:0]        pitch_t;
    typedef logic [15:0]        seg_layer_t;
    typedef logic [19:0]        turns_t;
    typedef logic [11:0]        rpm_t;
    typedef logic [15:0]        word16_t;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_PITCH  = 2'd0,
        REG_SPL    = 2'd1,
        REG_TARGET = 2'd2,
        REG_RPM    = 2'd3
    } reg_idx_t;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam pitch_t     PITCH_RST  = '0;
    localparam seg_layer_t SPL_RST    = 16'd1;
    localparam turns_t     TARGET_RST = '0;
    localparam rpm_t       RPM_RST    = '0;

    localparam int unsigned SIL_W   = 17;
    localparam logic [SIL_W-1:0] SIL_MAX = '1;
    localparam word16_t     WORD16_MAX = '1;

    // Speed path: rpm * segments/rev fits 21 bits for up to 256 segments/rev
    localparam int unsigned RS_W     = 21;
    localparam int unsigned SPD_SH_W = RS_W + 24 - 16;
    // (steps/s) = (rpm * spr * pitch >> 16) / 60, saturates at 60 * 2^16
    localparam logic [SPD_SH_W-1:0] SPD_LIMIT = 29'd3932160;
    localparam int unsigned SPD_X_W  = 22;
    localparam int unsigned SPD_SHIFT = 28;
    localparam logic [22:0] SPD_M    = 23'd4473925;

endpackage

@@ src/winding_traverse_sync.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+---------------------------------------------
// sample   | sample_valid / sample_stall | encoder_position
// result   | result_valid / result_stall | move_valid, move_steps, move_dir,
//          |                             | move_speed, layer_count, done_res
// config   | APB write/read              | psel, penable, pwrite, paddr, pwdata, prdata
//
// One request per cycle while sample_stall is low; three register stages from
// sample to result (input register, segment/state stage, result register).
// Segment division is a reciprocal multiply inside the state update loop. Reset
// clears control and state, but the direction register resets to 1; config takes
// reset values. A stalled result holds while the input register keeps filling;
// sample_stall rises only when all three stages are full.
module winding_traverse_sync #(
    parameter int unsigned COUNTS_PER_REV     = 4096,
    parameter int unsigned SEGMENTS_PER_REV   = 50,
    parameter int unsigned MIN_TRAVERSE_SPEED = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  wts_pkg::position_t                encoder_position,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              move_valid,
    output wts_pkg::word16_t                  move_steps,
    output logic                              move_dir,
    output wts_pkg::word16_t                  move_speed,
    output wts_pkg::word16_t                  layer_count,
    output logic                              done_res,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wts_pkg::PADDR_W-1:0]       paddr,
    input  logic [wts_pkg::PDATA_W-1:0]       pwdata,
    output logic [wts_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import wts_pkg::*;

    // Segment size and its reciprocal for exact floor division of 31-bit deltas
    localparam int unsigned SEG_RAW = COUNTS_PER_REV / SEGMENTS_PER_REV;
    localparam int unsigned SEG     = (SEG_RAW == 0) ? 1 : SEG_RAW;
    localparam int unsigned SEG_L   = $clog2(SEG);
    localparam logic [63:0] DIV_NUM = 64'd1 << (31 + SEG_L);
    localparam logic [63:0] SEG_M64 = (DIV_NUM + 64'(SEG) - 64'd1) / 64'(SEG);
    localparam logic [31:0] SEG_M   = SEG_M64[31:0];
    localparam logic [31:0] SEG32   = 32'(SEG);
    localparam logic [63:0] NSEG_MAX = 64'h7FFF_FFFF / 64'(SEG);
    localparam int unsigned NSEG_W  = $clog2(NSEG_MAX + 64'd1);

    // Done threshold: target * counts/rev, compared with nonnegative positions
    localparam int unsigned THR_W = 20 + $clog2(COUNTS_PER_REV + 1);
    localparam int unsigned CMP_W = (THR_W > 31) ? THR_W : 31;
    localparam logic [THR_W-1:0] CPR_C = THR_W'(COUNTS_PER_REV);
    localparam logic [RS_W-1:0]  SPR_C = RS_W'(SEGMENTS_PER_REV);
    localparam word16_t          MIN_SPD = 16'(MIN_TRAVERSE_SPEED);

    typedef struct packed {
        logic [NSEG_W-1:0] nseg;
        logic              dir;
        word16_t           layers;
        logic              done;
    } s1_t;

    // ---------------- configuration ----------------
    pitch_t     pitch_reg;
    seg_layer_t spl_reg;
    turns_t     target_reg;
    rpm_t       rpm_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PITCH_RST;
            spl_reg    <= SPL_RST;
            target_reg <= TARGET_RST;
            rpm_reg    <= RPM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PITCH:  pitch_reg  <= pwdata[23:0];
                REG_SPL:    spl_reg    <= pwdata[15:0];
                REG_TARGET: target_reg <= pwdata[19:0];
                REG_RPM:    rpm_reg    <= pwdata[11:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PITCH:  prdata = 32'(pitch_reg);
            REG_SPL:    prdata = 32'(spl_reg);
            REG_TARGET: prdata = 32'(target_reg);
            REG_RPM:    prdata = 32'(rpm_reg);
        endcase
    end

    // Config-derived values, registered (speed via spd_prod_reg, then spd_q_reg)
    logic [THR_W-1:0]       thr_reg;
    logic [RS_W+23:0]       spd_prod_reg;
    logic [15:0]            spd_q_reg;
    logic                   spd_sat_reg;
    logic [RS_W-1:0]        rs;
    logic [SPD_SH_W-1:0]    spd_sh;
    logic [SPD_X_W+22:0]    spd_mul;

    assign rs      = RS_W'(rpm_reg) * SPR_C;
    assign spd_sh  = spd_prod_reg[RS_W+23:16];
    assign spd_mul = spd_sh[SPD_X_W-1:0] * SPD_M;

    always_ff @(posedge clk)
    begin
        thr_reg      <= THR_W'(target_reg) * CPR_C;
        spd_prod_reg <= rs * (RS_W+24)'(pitch_reg);
        spd_sat_reg  <= (spd_sh >= SPD_LIMIT);
        spd_q_reg    <= spd_mul[SPD_SHIFT+15:SPD_SHIFT];
    end

    // ---------------- pipeline control ----------------
    logic smp_v_reg, smp_v_next;
    logic s1_v_reg,  s1_v_next;
    logic res_v_reg, res_v_next;
    logic out_ready, s1_ready, s1_to_out, advance0, sample_accept;

    assign out_ready     = !res_v_reg || !result_stall;
    assign s1_to_out     = s1_v_reg && out_ready;
    assign s1_ready      = !s1_v_reg || out_ready;
    assign advance0      = smp_v_reg && s1_ready;
    assign sample_stall  = smp_v_reg && !s1_ready;
    assign sample_accept = sample_valid && !sample_stall;
    assign result_valid  = res_v_reg;

    always_comb
    begin
        smp_v_next = sample_accept ? 1'b1 : (advance0 ? 1'b0 : smp_v_reg);
        s1_v_next  = advance0 ? 1'b1 : (s1_to_out ? 1'b0 : s1_v_reg);
        res_v_next = s1_to_out ? 1'b1 : (out_ready ? 1'b0 : res_v_reg);
    end

    // ---------------- input register ----------------
    position_t pos_reg;

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            pos_reg <= encoder_position;
        end
    end

    // ---------------- segment / state stage ----------------
    logic [31:0]       ref_reg, ref_next;
    logic              anch_reg, anch_next;
    logic [SIL_W-1:0]  sil_reg, sil_next;
    word16_t           layers_reg, layers_next;
    logic              dir_reg, dir_next;
    s1_t               s1_reg, s1_next;

    logic [31:0]       delta;
    logic              fwd;
    logic [62:0]       q_prod;
    logic [NSEG_W-1:0] q;
    logic [31:0]       sil_sum;
    logic [SIL_W-1:0]  sil_sat;
    logic [CMP_W-1:0]  pos_cmp, thr_cmp;
    logic              done_now;

    assign delta   = pos_reg - ref_reg;
    assign fwd     = (delta != 32'd0) && !delta[31];
    assign q_prod  = 63'(delta[30:0]) * 63'(SEG_M);
    assign q       = q_prod[31+SEG_L +: NSEG_W];
    assign sil_sum = 32'(sil_reg) + 32'(q);
    assign sil_sat = (sil_sum > 32'(SIL_MAX)) ? SIL_MAX : sil_sum[SIL_W-1:0];
    assign pos_cmp = CMP_W'(pos_reg[30:0]);
    assign thr_cmp = CMP_W'(thr_reg);
    // negative positions count as zero turns
    assign done_now = pos_reg[31] ? (target_reg == '0) : (pos_cmp >= thr_cmp);

    always_comb
    begin
        ref_next    = ref_reg;
        anch_next   = anch_reg;
        sil_next    = sil_reg;
        layers_next = layers_reg;
        dir_next    = dir_reg;
        s1_next     = s1_reg;
        if (advance0)
        begin
            s1_next.nseg = '0;
            if (!anch_reg)
            begin
                // first sample only anchors the reference
                ref_next  = pos_reg;
                anch_next = 1'b1;
            end
            else if (fwd && (q != '0))
            begin
                s1_next.nseg = q;
                ref_next     = ref_reg + 32'(q) * SEG32;
                sil_next     = sil_sat;
                if (32'(sil_sat) >= 32'(spl_reg))
                begin
                    sil_next = '0;
                    dir_next = !dir_reg;
                    if (layers_reg != WORD16_MAX)
                    begin
                        layers_next = layers_reg + 16'd1;
                    end
                end
            end
            s1_next.dir    = dir_next;
            s1_next.layers = layers_next;
            s1_next.done   = done_now;
        end
    end

    // ---------------- result stage ----------------
    logic [NSEG_W+23:0] stp_prod;
    logic [NSEG_W+7:0]  stp_sh;
    logic               stp_nz, stp_sat;
    word16_t            steps_next, speed_next;
    word16_t            steps_reg, speed_reg, res_layers_reg;
    logic               mv_reg, res_dir_reg, res_done_reg;

    assign stp_prod = (NSEG_W+24)'(s1_reg.nseg) * (NSEG_W+24)'(pitch_reg);
    assign stp_sh   = stp_prod[NSEG_W+23:16];
    assign stp_nz   = (stp_sh != '0);
    assign stp_sat  = |stp_sh[NSEG_W+7:16];

    always_comb
    begin
        steps_next = '0;
        speed_next = '0;
        if (stp_nz)
        begin
            steps_next = stp_sat ? WORD16_MAX : stp_sh[15:0];
            if (spd_sat_reg)
            begin
                speed_next = WORD16_MAX;
            end
            else
            begin
                speed_next = (spd_q_reg < MIN_SPD) ? MIN_SPD : spd_q_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_to_out)
        begin
            mv_reg         <= stp_nz;
            steps_reg      <= steps_next;
            speed_reg      <= speed_next;
            res_dir_reg    <= s1_reg.dir;
            res_layers_reg <= s1_reg.layers;
            res_done_reg   <= s1_reg.done;
        end
    end

    assign move_valid  = mv_reg;
    assign move_steps  = steps_reg;
    assign move_dir    = res_dir_reg;
    assign move_speed  = speed_reg;
    assign layer_count = res_layers_reg;
    assign done_res    = res_done_reg;

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_v_reg  <= 1'b0;
            s1_v_reg   <= 1'b0;
            res_v_reg  <= 1'b0;
            ref_reg    <= '0;
            anch_reg   <= 1'b0;
            sil_reg    <= '0;
            layers_reg <= '0;
            dir_reg    <= 1'b1;
            s1_reg     <= '0;
        end
        else
        begin
            smp_v_reg  <= smp_v_next;
            s1_v_reg   <= s1_v_next;
            res_v_reg  <= res_v_next;
            ref_reg    <= ref_next;
            anch_reg   <= anch_next;
            sil_reg    <= sil_next;
            layers_reg <= layers_next;
            dir_reg    <= dir_next;
            s1_reg     <= s1_next;
        end
    end

endmodule
